// File: rtl/sveg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sveg_pkg
// Shared types and constants of the state vector gate engine.
// ----------------------------------------------------------------------------
package sveg_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_BITS_DEF   = 18;

    localparam int CMD_W     = 3;
    localparam int QUBIT_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int NORM_W    = 36;
    localparam int QCFG_W    = 4;
    localparam int SEED_W    = 64;
    localparam int TOL_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int IN_W      = 16;

    localparam logic [QCFG_W-1:0] QUBITS_RST  = 4'd1;
    localparam logic [TOL_W-1:0]  TOL_RST     = 32'd4295;
    localparam logic [SEED_W-1:0] DEFAULT_SEED = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0]       RNG_MULT     = 64'd2685821657736338717;
    localparam logic signed [17:0] INV_SQRT2_Q17 = 18'sd92682;
    localparam logic [NORM_W-1:0] NORM_ONE     = 36'h1_0000_0000;

    typedef enum logic [2:0] {
        CMD_RESET   = 3'd0,
        CMD_H       = 3'd1,
        CMD_X       = 3'd2,
        CMD_CX      = 3'd3,
        CMD_GHZ     = 3'd4,
        CMD_MEASURE = 3'd5,
        CMD_SAMPLE  = 3'd6,
        CMD_NORM    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NORM  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_QUBITS = 2'd0,
        REG_SEED   = 2'd1,
        REG_TOL    = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_RESET,
        OP_H,
        OP_X,
        OP_CX,
        OP_GHZ,
        OP_MEASURE,
        OP_SAMPLE,
        OP_NORM,
        OP_ERROR
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [QUBIT_W-1:0]   qa;
        logic [QUBIT_W-1:0]   qb;
    } op_t;

    typedef struct packed {
        logic              qubits_we;
        logic              seed_we;
        logic [SEED_W-1:0] seed;
    } cfg_ev_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        VM_MEM,
        VM_BASIS,
        VM_GHZ
    } vmode_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PASS,
        BK_DRAW,
        BK_MUL0,
        BK_MUL1,
        BK_MUL2,
        BK_THR,
        BK_WALK,
        BK_DONE
    } bk_state_t;

endpackage

// File: rtl/sveg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sveg_front
// Accepts commands, range-checks qubit numbers and classifies each one.
// ----------------------------------------------------------------------------
module sveg_front
    import sveg_pkg::*;
#(
    parameter int MAX_QUBITS = MAX_QUBITS_DEF
) (
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [CMD_W-1:0]                     command,
    input  logic [QUBIT_W-1:0]                   qubit_a,
    input  logic [QUBIT_W-1:0]                   qubit_b,
    input  logic [$clog2(MAX_QUBITS+1)-1:0]      nq,
    input  q_stat_t                              q_stat,
    output logic                                 push,
    output op_t                                  op
);

    logic qa_bad;
    logic qb_bad;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        qa_bad  = 5'(qubit_a) >= 5'(nq);
        qb_bad  = 5'(qubit_b) >= 5'(nq);
        op.qa   = qubit_a;
        op.qb   = qubit_b;
        unique case (cmd_t'(command))
            CMD_RESET:   op.kind = OP_RESET;
            CMD_H:       op.kind = qa_bad ? OP_ERROR : OP_H;
            CMD_X:       op.kind = qa_bad ? OP_ERROR : OP_X;
            CMD_CX:      op.kind = (qa_bad || qb_bad || qubit_a == qubit_b) ? OP_ERROR : OP_CX;
            CMD_GHZ:     op.kind = OP_GHZ;
            CMD_MEASURE: op.kind = OP_MEASURE;
            CMD_SAMPLE:  op.kind = OP_SAMPLE;
            CMD_NORM:    op.kind = OP_NORM;
        endcase
    end

endmodule

// File: rtl/sveg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sveg_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module sveg_queue
    import sveg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_t     push_op,
    input  logic    pop,
    output op_t     head_op,
    output q_stat_t q_stat
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head_op      = slot_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == 2'd2;
    assign q_stat.empty = count_reg == 2'd0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: rtl/sveg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sveg_back
// Sequencer that runs one command over the amplitude memory.
// ----------------------------------------------------------------------------
module sveg_back
    import sveg_pkg::*;
#(
    parameter int MAX_QUBITS = MAX_QUBITS_DEF,
    parameter int AMP_BITS   = AMP_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(MAX_QUBITS+1)-1:0] nq,
    input  logic [TOL_W-1:0]                tol,
    input  cfg_ev_t                         cfg_ev,
    input  q_stat_t                         q_stat,
    input  op_t                             head_op,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [STATUS_W-1:0]             out_status,
    output logic [MAX_QUBITS-1:0]           out_index,
    output logic [NORM_W-1:0]               out_norm,
    output logic                            out_collapsed
);

    localparam int AW     = MAX_QUBITS;
    localparam int DEPTH  = 1 << AW;
    localparam int KW     = AW + 1;
    localparam int EW     = 2 * AMP_BITS;
    localparam int SUM_W  = AMP_BITS + 1;
    localparam int PRD_W  = SUM_W + 18;
    localparam int F2     = 2 * (AMP_BITS - 2);
    localparam int PSH_L  = (F2 < 32) ? 32 - F2 : 0;
    localparam int PSH_R  = (F2 >= 32) ? F2 - 32 : 0;
    localparam int SQ_W   = 2 * AMP_BITS;
    localparam int PROB_W = SQ_W + PSH_L;
    localparam int ACC_W  = PROB_W + AW;
    localparam longint HALF_L = ((longint'(1) << (AMP_BITS - 2)) * 92682 + 65536) >>> 17;
    localparam logic signed [AMP_BITS-1:0] AMP_ONE  = AMP_BITS'(longint'(1) << (AMP_BITS - 2));
    localparam logic signed [AMP_BITS-1:0] AMP_HALF = AMP_BITS'(HALF_L);
    localparam logic signed [PRD_W-1:0] AMP_MAX = PRD_W'((longint'(1) << (AMP_BITS - 1)) - 1);
    localparam logic signed [PRD_W-1:0] AMP_MIN = -PRD_W'(longint'(1) << (AMP_BITS - 1));
    localparam logic signed [PRD_W-1:0] RND_HALF = PRD_W'(65536);

    // amplitude store, {real, imag} per entry
    logic [EW-1:0] amp_mem [DEPTH];
    logic [EW-1:0] q_a_reg;
    logic [EW-1:0] q_b_reg;

    bk_state_t state_reg, state_next;
    vmode_t    mode_reg;
    op_t       op_reg;
    logic [KW-1:0]     k_reg;
    logic [AW-1:0]     basis_reg;
    logic              collapsed_reg;
    logic [SEED_W-1:0] rng_reg;
    logic [SEED_W-1:0] draw_reg;
    logic [63:0]       mul_reg;
    logic [31:0]       thr_reg;
    logic [AW-1:0]     tmask_reg;
    logic [AW-1:0]     cmask_reg;
    logic [AW-1:0]     ra_reg, rb_reg;
    logic [AW-1:0]     wi_reg, wj_reg;
    logic [EW-1:0]     a_reg, b_reg;
    logic              swap_reg;
    logic              hgate_reg;
    logic signed [PRD_W-1:0] p_sr_reg, p_si_reg, p_dr_reg, p_di_reg;
    logic [SQ_W-1:0]   sq_re_reg, sq_im_reg;
    logic [AW-1:0]     sq_idx_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              found_reg;
    logic [AW-1:0]     hit_reg;
    logic              out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [AW-1:0]     out_index_reg;
    logic [NORM_W-1:0] out_norm_reg;
    logic              out_collapsed_reg;

    // control decoded from state and walk counter
    logic              rd_en;
    logic [AW-1:0]     rd_a, rd_b;
    logic              we;
    logic [AW-1:0]     wa;
    logic [EW-1:0]     wd;
    logic              mul_stage;
    logic              sq_stage;
    logic              acc_stage;
    logic              out_load;
    logic              step_end;

    logic [KW-1:0]     cnt_ext;
    logic [AW-1:0]     last_idx;
    logic [AW-1:0]     pair;
    logic [AW-1:0]     low_mask;
    logic [AW-1:0]     pair_i;
    logic [EW-1:0]     amp_a, amp_b;
    logic [63:0]       v0, v1, v2, v3;
    logic [31:0]       mul_x, mul_y;
    logic [ACC_W-1:0]  prob, acc_new;
    logic [NORM_W-1:0] norm_sat, dev;
    logic [4:0]        pos_a, pos_b;

    logic [STATUS_W-1:0] res_status;
    logic [AW-1:0]       res_index;
    logic [NORM_W-1:0]   res_norm;
    logic                res_collapsed;

    function automatic logic [EW-1:0] virt_amp(vmode_t m, logic [AW-1:0] addr,
                                               logic [AW-1:0] basis, logic [AW-1:0] last);
        logic signed [AMP_BITS-1:0] re;
        re = '0;
        unique case (m)
            VM_BASIS: re = (addr == basis) ? AMP_ONE : '0;
            VM_GHZ:   re = (addr == '0 || addr == last) ? AMP_HALF : '0;
            default:  re = '0;
        endcase
        return {re, AMP_BITS'(0)};
    endfunction

    function automatic logic [AMP_BITS-1:0] h_sat(logic signed [PRD_W-1:0] p);
        logic signed [PRD_W-1:0] t;
        t = (p + RND_HALF) >>> 17;
        if (t > AMP_MAX)
        begin
            t = AMP_MAX;
        end
        else if (t < AMP_MIN)
        begin
            t = AMP_MIN;
        end
        return t[AMP_BITS-1:0];
    endfunction

    assign cnt_ext  = KW'(1) << nq;
    assign last_idx = AW'(cnt_ext - KW'(1));
    assign pair     = k_reg[KW-1:1];
    assign low_mask = tmask_reg - AW'(1);
    assign pair_i   = ((pair & ~low_mask) << 1) | (pair & low_mask);
    assign amp_a    = (mode_reg == VM_MEM) ? q_a_reg
                                           : virt_amp(mode_reg, ra_reg, basis_reg, last_idx);
    assign amp_b    = (mode_reg == VM_MEM) ? q_b_reg
                                           : virt_amp(mode_reg, rb_reg, basis_reg, last_idx);

    // xorshift64* state update
    always_comb
    begin
        v0 = (rng_reg == '0) ? DEFAULT_SEED : rng_reg;
        v1 = v0 ^ (v0 >> 12);
        v2 = v1 ^ (v1 << 25);
        v3 = v2 ^ (v2 >> 27);
    end

    // shared 32x32 multiplier for the top half of the low product word
    always_comb
    begin
        priority case (state_reg)
            BK_MUL1: begin mul_x = draw_reg[63:32]; mul_y = RNG_MULT[31:0];  end
            BK_MUL2: begin mul_x = draw_reg[31:0];  mul_y = RNG_MULT[63:32]; end
            default: begin mul_x = draw_reg[31:0];  mul_y = RNG_MULT[31:0];  end
        endcase
    end

    always_comb
    begin
        prob     = (ACC_W'(sq_re_reg + sq_im_reg) << PSH_L) >> PSH_R;
        acc_new  = acc_reg + prob;
        norm_sat = (|acc_reg[ACC_W-1:NORM_W]) ? '1 : acc_reg[NORM_W-1:0];
        dev      = (norm_sat >= NORM_ONE) ? norm_sat - NORM_ONE : NORM_ONE - norm_sat;
        pos_a    = 5'(nq) - 5'd1 - 5'(head_op.qa);
        pos_b    = 5'(nq) - 5'd1 - 5'(head_op.qb);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    unique case (head_op.kind)
                        OP_H, OP_X, OP_CX:      state_next = BK_PASS;
                        OP_MEASURE, OP_SAMPLE:  state_next = BK_DRAW;
                        OP_NORM:                state_next = BK_WALK;
                        default:                state_next = BK_DONE;
                    endcase
                end
            end
            BK_PASS: if (step_end) state_next = BK_DONE;
            BK_DRAW: state_next = BK_MUL0;
            BK_MUL0: state_next = BK_MUL1;
            BK_MUL1: state_next = BK_MUL2;
            BK_MUL2: state_next = BK_THR;
            BK_THR:  state_next = BK_WALK;
            BK_WALK: if (step_end) state_next = BK_DONE;
            BK_DONE: if (out_load) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        rd_a      = pair_i;
        rd_b      = pair_i | tmask_reg;
        we        = 1'b0;
        wa        = wi_reg;
        wd        = '0;
        mul_stage = 1'b0;
        sq_stage  = 1'b0;
        acc_stage = 1'b0;
        step_end  = k_reg == cnt_ext + KW'(1);
        out_load  = (state_reg == BK_DONE) && (!out_valid_reg || out_ready);
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = !q_stat.empty;
            end
            BK_PASS:
            begin
                rd_en     = !k_reg[0] && (k_reg < cnt_ext);
                mul_stage = k_reg[0] && (k_reg < cnt_ext);
                if (!k_reg[0] && k_reg >= KW'(2) && k_reg <= cnt_ext)
                begin
                    we = 1'b1;
                    wa = wi_reg;
                    wd = hgate_reg ? {h_sat(p_sr_reg), h_sat(p_si_reg)}
                                   : (swap_reg ? b_reg : a_reg);
                end
                else if (k_reg[0] && k_reg >= KW'(3))
                begin
                    we = 1'b1;
                    wa = wj_reg;
                    wd = hgate_reg ? {h_sat(p_dr_reg), h_sat(p_di_reg)}
                                   : (swap_reg ? a_reg : b_reg);
                end
            end
            BK_WALK:
            begin
                rd_en     = k_reg < cnt_ext;
                rd_a      = AW'(k_reg);
                rd_b      = AW'(k_reg);
                sq_stage  = (k_reg >= KW'(1)) && (k_reg <= cnt_ext);
                acc_stage = k_reg >= KW'(2);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        res_status    = ST_OK;
        res_index     = '0;
        res_norm      = '0;
        res_collapsed = collapsed_reg;
        unique case (op_reg.kind)
            OP_RESET, OP_H, OP_X, OP_CX, OP_GHZ:
            begin
                res_collapsed = 1'b0;
            end
            OP_MEASURE:
            begin
                res_index     = found_reg ? hit_reg : last_idx;
                res_collapsed = 1'b1;
            end
            OP_SAMPLE:
            begin
                res_index = found_reg ? hit_reg : last_idx;
            end
            OP_NORM:
            begin
                res_norm   = norm_sat;
                res_status = (dev > NORM_W'(tol)) ? ST_NORM : ST_OK;
            end
            OP_ERROR:
            begin
                res_status = ST_RANGE;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_a_reg <= amp_mem[rd_a];
            q_b_reg <= amp_mem[rd_b];
        end
        if (we)
        begin
            amp_mem[wa] <= wd;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg    <= head_op;
            tmask_reg <= AW'(1) << ((head_op.kind == OP_CX) ? pos_b : pos_a);
            cmask_reg <= AW'(1) << pos_a;
        end
        if (rd_en)
        begin
            ra_reg <= rd_a;
            rb_reg <= rd_b;
        end
        if (mul_stage)
        begin
            wi_reg    <= ra_reg;
            wj_reg    <= rb_reg;
            a_reg     <= amp_a;
            b_reg     <= amp_b;
            hgate_reg <= op_reg.kind == OP_H;
            swap_reg  <= (op_reg.kind == OP_X) ||
                         ((op_reg.kind == OP_CX) && ((ra_reg & cmask_reg) != '0));
            p_sr_reg  <= (SUM_W'($signed(amp_a[EW-1:AMP_BITS])) +
                          SUM_W'($signed(amp_b[EW-1:AMP_BITS]))) * INV_SQRT2_Q17;
            p_si_reg  <= (SUM_W'($signed(amp_a[AMP_BITS-1:0])) +
                          SUM_W'($signed(amp_b[AMP_BITS-1:0]))) * INV_SQRT2_Q17;
            p_dr_reg  <= (SUM_W'($signed(amp_a[EW-1:AMP_BITS])) -
                          SUM_W'($signed(amp_b[EW-1:AMP_BITS]))) * INV_SQRT2_Q17;
            p_di_reg  <= (SUM_W'($signed(amp_a[AMP_BITS-1:0])) -
                          SUM_W'($signed(amp_b[AMP_BITS-1:0]))) * INV_SQRT2_Q17;
        end
        if (sq_stage)
        begin
            sq_re_reg  <= SQ_W'($signed(amp_a[EW-1:AMP_BITS]) * $signed(amp_a[EW-1:AMP_BITS]));
            sq_im_reg  <= SQ_W'($signed(amp_a[AMP_BITS-1:0]) * $signed(amp_a[AMP_BITS-1:0]));
            sq_idx_reg <= ra_reg;
        end
        if (state_reg == BK_DRAW)
        begin
            draw_reg <= v3;
        end
        mul_reg <= 64'(mul_x) * 64'(mul_y);
        if (state_reg == BK_MUL1)
        begin
            thr_reg <= mul_reg[63:32];
        end
        else if (state_reg == BK_MUL2 || state_reg == BK_THR)
        begin
            thr_reg <= thr_reg + mul_reg[31:0];
        end
        if (pop)
        begin
            acc_reg <= '0;
        end
        else if (acc_stage)
        begin
            acc_reg <= acc_new;
        end
        if (acc_stage && !found_reg && (ACC_W'(thr_reg) < acc_new))
        begin
            hit_reg <= sq_idx_reg;
        end
        if (out_load)
        begin
            out_status_reg    <= res_status;
            out_index_reg     <= res_index;
            out_norm_reg      <= res_norm;
            out_collapsed_reg <= res_collapsed;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            k_reg         <= '0;
            mode_reg      <= VM_BASIS;
            basis_reg     <= '0;
            collapsed_reg <= 1'b0;
            rng_reg       <= DEFAULT_SEED;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                k_reg     <= '0;
                found_reg <= 1'b0;
            end
            else if (state_reg == BK_PASS || state_reg == BK_WALK)
            begin
                k_reg <= k_reg + KW'(1);
                if (acc_stage && (ACC_W'(thr_reg) < acc_new))
                begin
                    found_reg <= 1'b1;
                end
            end
            if (state_reg == BK_DRAW)
            begin
                rng_reg <= v3;
            end
            if (out_load)
            begin
                collapsed_reg <= res_collapsed;
                unique case (op_reg.kind)
                    OP_RESET:
                    begin
                        mode_reg  <= VM_BASIS;
                        basis_reg <= '0;
                    end
                    OP_H, OP_X, OP_CX:
                    begin
                        mode_reg <= VM_MEM;
                    end
                    OP_GHZ:
                    begin
                        mode_reg <= VM_GHZ;
                    end
                    OP_MEASURE:
                    begin
                        mode_reg  <= VM_BASIS;
                        basis_reg <= res_index;
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
            if (cfg_ev.qubits_we)
            begin
                mode_reg      <= VM_BASIS;
                basis_reg     <= '0;
                collapsed_reg <= 1'b0;
            end
            if (cfg_ev.seed_we)
            begin
                rng_reg <= (cfg_ev.seed == '0) ? DEFAULT_SEED : cfg_ev.seed;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_index     = out_index_reg;
    assign out_norm      = out_norm_reg;
    assign out_collapsed = out_collapsed_reg;

endmodule

// File: rtl/state_vector_gate_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_vector_gate_engine
// State vector simulator: gates, GHZ, measure, sample and norm check.
// ----------------------------------------------------------------------------
// Flow: H, X and CX walk the amplitude pairs and write each pair back one
//   amplitude at a time through the single write port of the amplitude memory;
//   norm check walks every amplitude; measure and sample run a generator draw
//   before that walk; reset, GHZ and bad qubit numbers finish without a walk.
// Sequencing: one command at a time in the back end; the front queue holds two
//   more commands meanwhile.
// Reset: async active low. No clearing pass: the memory contents are undefined
//   after reset and a basis-0 view stands in for them until a gate rewrites it.
module state_vector_gate_engine
    import sveg_pkg::*;
#(
    parameter int MAX_QUBITS = MAX_QUBITS_DEF,
    parameter int AMP_BITS   = AMP_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // command stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] command, [6:3] qubit_a, [10:7] qubit_b, rest zero
    input  logic [IN_W-1:0]      s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] status, [MAX_QUBITS+1:2] measured_index, next 36 norm_value,
    // then is_collapsed, rest zero
    output logic [((MAX_QUBITS+39+7)/8)*8-1:0] m_axis_tdata,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NW    = $clog2(MAX_QUBITS + 1);
    localparam int OUT_W = ((MAX_QUBITS + 39 + 7) / 8) * 8;

    logic [QCFG_W-1:0] qubits_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [NW-1:0]     nq;
    cfg_ev_t           cfg_ev;
    logic              cfg_fire;

    q_stat_t q_stat;
    op_t     push_op;
    op_t     head_op;
    logic    push;
    logic    pop;

    logic [STATUS_W-1:0]   status;
    logic [MAX_QUBITS-1:0] measured_index;
    logic [NORM_W-1:0]     norm_value;
    logic                  is_collapsed;

    // config transactions are always accepted, cfg_ready is tied high
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_ev.qubits_we = 1'b0;
        cfg_ev.seed_we   = 1'b0;
        cfg_ev.seed      = cfg_data;
        unique case (cfg_reg_t'(cfg_index))
            REG_QUBITS: cfg_ev.qubits_we = cfg_fire;
            REG_SEED:   cfg_ev.seed_we   = cfg_fire;
            default:    cfg_ev.seed_we   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qubits_reg <= QUBITS_RST;
            tol_reg    <= TOL_RST;
        end
        else
        begin
            if (cfg_ev.qubits_we)
            begin
                qubits_reg <= cfg_data[QCFG_W-1:0];
            end
            if (cfg_fire && cfg_index == REG_TOL)
            begin
                tol_reg <= cfg_data[TOL_W-1:0];
            end
        end
    end

    // zero acts as one qubit, anything past the memory size acts as the max
    always_comb
    begin
        if (qubits_reg == '0)
        begin
            nq = NW'(1);
        end
        else if (5'(qubits_reg) > 5'(MAX_QUBITS))
        begin
            nq = NW'(MAX_QUBITS);
        end
        else
        begin
            nq = NW'(qubits_reg);
        end
    end

    sveg_front #(
        .MAX_QUBITS (MAX_QUBITS)
    ) u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .command  (s_axis_tdata[2:0]),
        .qubit_a  (s_axis_tdata[6:3]),
        .qubit_b  (s_axis_tdata[10:7]),
        .nq       (nq),
        .q_stat   (q_stat),
        .push     (push),
        .op       (push_op)
    );

    sveg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat)
    );

    sveg_back #(
        .MAX_QUBITS (MAX_QUBITS),
        .AMP_BITS   (AMP_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .nq            (nq),
        .tol           (tol_reg),
        .cfg_ev        (cfg_ev),
        .q_stat        (q_stat),
        .head_op       (head_op),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_status    (status),
        .out_index     (measured_index),
        .out_norm      (norm_value),
        .out_collapsed (is_collapsed)
    );

    assign m_axis_tdata = OUT_W'({is_collapsed, norm_value, measured_index, status});

`ifndef SYNTH
    // only measure and sample report an index, and they never fail
    a_index_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status != ST_OK |-> measured_index == '0)
        else $error("index reported with a failing status");

    // a norm value comes from the norm check alone
    a_norm_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && norm_value != '0 |-> measured_index == '0 && status != ST_RANGE)
        else $error("norm value on a non-norm result");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for state_vector_gate_engine. A local fixed-point
// state-vector predictor tracks amplitudes, the xorshift generator and the
// collapse flag. Every result transaction is checked field by field against
// the oldest prediction. Directed cases come first, then random gate
// sequences over several qubit counts, with random idling on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import sveg_pkg::*;

    localparam int OUT_W    = ((MAX_QUBITS_DEF + 39 + 7) / 8) * 8;
    localparam int DEPTH    = 1 << MAX_QUBITS_DEF;
    localparam longint AMP_ONE = 64'sd1 <<< (AMP_BITS_DEF - 2);
    localparam longint AMP_HI  = (64'sd1 <<< (AMP_BITS_DEF - 1)) - 1;
    localparam longint AMP_LO  = -(64'sd1 <<< (AMP_BITS_DEF - 1));
    localparam logic [63:0] NORM_SAT = (64'd1 << NORM_W) - 1;

    typedef struct {
        cmd_t               cmd;
        logic [QUBIT_W-1:0] qa;
        logic [QUBIT_W-1:0] qb;
    } gate_cmd_t;

    typedef struct {
        status_t                   status;
        logic [MAX_QUBITS_DEF-1:0] index;
        logic [NORM_W-1:0]         norm;
        logic                      collapsed;
    } engine_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;   // [2:0] command, [6:3] qubit_a, [10:7] qubit_b
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [1:0] status, [11:2] measured_index, [47:12] norm_value, [48] is_collapsed
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    state_vector_gate_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ---------------- predictor state ----------------
    longint          amp_re [DEPTH];
    longint          amp_im [DEPTH];
    logic [63:0]     gen_word;
    logic            collapse_flag;
    logic [3:0]      qubit_reg;
    logic [31:0]     tol_reg;

    engine_result_t  pending_results [$];
    int              fail_count;
    int              sent_count;
    int              checked_count;
    int              draw_count;
    bit              sender_idle;
    bit              receiver_idle;
    int              rx_holdoff;       // one-shot long stall requested by a test

    function automatic int active_qubits();
        if (qubit_reg == 0) return 1;
        if (qubit_reg > MAX_QUBITS_DEF) return MAX_QUBITS_DEF;
        return qubit_reg;
    endfunction

    function automatic void load_basis(int idx);
        for (int i = 0; i < DEPTH; i++)
        begin
            amp_re[i] = 0;
            amp_im[i] = 0;
        end
        amp_re[idx] = AMP_ONE;
    endfunction

    // xorshift64* step; a zero word falls back to the default seed
    function automatic logic [63:0] rng_next();
        logic [63:0] v;
        v = (gen_word == 0) ? DEFAULT_SEED : gen_word;
        v ^= v >> 12;
        v ^= v << 25;
        v ^= v >> 27;
        gen_word = v;
        return v * RNG_MULT;
    endfunction

    // round to nearest (ties up), floor shift, saturate
    function automatic longint hadamard_scale(longint s);
        longint r;
        r = s * longint'(INV_SQRT2_Q17) + 65536;
        r = r >>> 17;
        if (r > AMP_HI) r = AMP_HI;
        if (r < AMP_LO) r = AMP_LO;
        return r;
    endfunction

    function automatic void apply_h(int q);
        int n;
        int mask;
        longint ar, ai, br, bi;
        n = active_qubits();
        mask = 1 << (n - 1 - q);
        for (int i = 0; i < (1 << n); i++)
        begin
            if ((i & mask) == 0)
            begin
                ar = amp_re[i];        ai = amp_im[i];
                br = amp_re[i | mask]; bi = amp_im[i | mask];
                amp_re[i]        = hadamard_scale(ar + br);
                amp_im[i]        = hadamard_scale(ai + bi);
                amp_re[i | mask] = hadamard_scale(ar - br);
                amp_im[i | mask] = hadamard_scale(ai - bi);
            end
        end
    endfunction

    function automatic void swap_amps(int i, int j);
        longint t;
        t = amp_re[i]; amp_re[i] = amp_re[j]; amp_re[j] = t;
        t = amp_im[i]; amp_im[i] = amp_im[j]; amp_im[j] = t;
    endfunction

    // ctrl < 0 means plain X
    function automatic void apply_flip(int ctrl, int tgt);
        int n;
        int cm;
        int tm;
        n = active_qubits();
        tm = 1 << (n - 1 - tgt);
        cm = (ctrl < 0) ? 0 : (1 << (n - 1 - ctrl));
        for (int i = 0; i < (1 << n); i++)
            if (((i & cm) == cm) && ((i & tm) == 0))
                swap_amps(i, i | tm);
    endfunction

    function automatic logic [63:0] basis_prob(int i);
        return 64'(amp_re[i] * amp_re[i] + amp_im[i] * amp_im[i]);
    endfunction

    // cumulative walk against the top 32 bits of a fresh draw
    function automatic int draw_basis_index();
        logic [63:0] thr;
        logic [63:0] cum;
        int cnt;
        cnt = 1 << active_qubits();
        thr = rng_next() >> 32;
        cum = 0;
        for (int i = 0; i + 1 < cnt; i++)
        begin
            cum += basis_prob(i);
            if (thr < cum) return i;
        end
        return cnt - 1;
    endfunction

    function automatic engine_result_t predict_command(gate_cmd_t c);
        engine_result_t r;
        int n;
        logic [63:0] sum;
        logic [63:0] dev;
        n = active_qubits();
        r.status = ST_OK;
        r.index = '0;
        r.norm = '0;
        case (c.cmd)
            CMD_RESET:
            begin
                load_basis(0);
                collapse_flag = 1'b0;
            end
            CMD_H, CMD_X:
            begin
                if (c.qa >= n)
                    r.status = ST_RANGE;
                else
                begin
                    if (c.cmd == CMD_H) apply_h(c.qa);
                    else apply_flip(-1, c.qa);
                    collapse_flag = 1'b0;
                end
            end
            CMD_CX:
            begin
                if (c.qa >= n || c.qb >= n || c.qa == c.qb)
                    r.status = ST_RANGE;
                else
                begin
                    apply_flip(c.qa, c.qb);
                    collapse_flag = 1'b0;
                end
            end
            CMD_GHZ:
            begin
                load_basis(0);
                apply_h(0);
                for (int q = 1; q < n; q++) apply_flip(q - 1, q);
                collapse_flag = 1'b0;
            end
            CMD_MEASURE:
            begin
                r.index = MAX_QUBITS_DEF'(draw_basis_index());
                load_basis(r.index);
                collapse_flag = 1'b1;
                draw_count++;
            end
            CMD_SAMPLE:
            begin
                r.index = MAX_QUBITS_DEF'(draw_basis_index());
                draw_count++;
            end
            default:
            begin
                sum = 0;
                for (int i = 0; i < (1 << n); i++) sum += basis_prob(i);
                if (sum > NORM_SAT) sum = NORM_SAT;
                r.norm = sum[NORM_W-1:0];
                dev = (sum >= 64'h1_0000_0000) ? sum - 64'h1_0000_0000
                                               : 64'h1_0000_0000 - sum;
                if (dev > {32'd0, tol_reg}) r.status = ST_NORM;
            end
        endcase
        r.collapsed = collapse_flag;
        return r;
    endfunction

    // ---------------- clock, reset, limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout: %0d results still pending", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // ---------------- result checker ----------------
    // Draws a per-transaction stall, honors a long hold-off when a test asks.
    initial
    begin : result_monitor
        engine_result_t exp_r;
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = receiver_idle ? $urandom_range(0, 5) : 0;
            if (rx_holdoff > 0)
            begin
                stall = rx_holdoff;
                rx_holdoff = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            checked_count++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result transaction %h", $realtime, m_axis_tdata);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== exp_r.status ||
                    m_axis_tdata[11:2] !== exp_r.index ||
                    m_axis_tdata[47:12] !== exp_r.norm ||
                    m_axis_tdata[48] !== exp_r.collapsed)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: mismatch exp st=%0d idx=%0d norm=%h col=%0b",
                                 $realtime, exp_r.status, exp_r.index, exp_r.norm,
                                 exp_r.collapsed);
                        $display("    got st=%0d idx=%0d norm=%h col=%0b",
                                 m_axis_tdata[1:0], m_axis_tdata[11:2],
                                 m_axis_tdata[47:12], m_axis_tdata[48]);
                    end
                end
            end
        end
    end

    // ---------------- shared driver tasks ----------------
    task automatic send_command(cmd_t cmd, int qa, int qb);
        gate_cmd_t c;
        int gap;
        c.cmd = cmd;
        c.qa = qa[3:0];
        c.qb = qb[3:0];
        gap = sender_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, c.qb, c.qa, c.cmd};
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(predict_command(c));
        sent_count++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // only called while idle
    task automatic write_register(cfg_reg_t idx, logic [63:0] value);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_QUBITS:
            begin
                qubit_reg = value[3:0];
                load_basis(0);
                collapse_flag = 1'b0;
            end
            REG_SEED: gen_word = (value == 0) ? DEFAULT_SEED : value;
            default:  tol_reg = value[31:0];
        endcase
    endtask

    // ---------------- test tasks ----------------
    task automatic test_defaults_one_qubit();
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        send_command(CMD_NORM, 0, 0);
        send_command(CMD_SAMPLE, 0, 0);
        send_command(CMD_H, 0, 15);
        send_command(CMD_NORM, 0, 0);
        send_command(CMD_MEASURE, 0, 0);
        send_command(CMD_SAMPLE, 0, 0);
        send_command(CMD_X, 0, 0);
        send_command(CMD_H, 15, 0);      // target out of range
        send_command(CMD_X, 1, 0);
        send_command(CMD_CX, 0, 0);      // control equals target
        send_command(CMD_RESET, 9, 9);
    endtask

    task automatic test_multi_qubit_gates();
        write_register(REG_QUBITS, 3);
        write_register(REG_SEED, 0);     // zero falls back to default seed
        send_command(CMD_GHZ, 0, 0);
        send_command(CMD_NORM, 0, 0);
        send_command(CMD_SAMPLE, 0, 0);
        send_command(CMD_MEASURE, 0, 0);
        send_command(CMD_CX, 0, 2);
        send_command(CMD_CX, 1, 1);
        send_command(CMD_CX, 3, 0);
        send_command(CMD_CX, 0, 15);
        send_command(CMD_H, 2, 0);
        send_command(CMD_X, 1, 0);
        write_register(REG_TOL, 0);      // only an exact norm passes
        send_command(CMD_NORM, 0, 0);
        write_register(REG_TOL, 32'hFFFF_FFFF);
        send_command(CMD_H, 0, 0);
        send_command(CMD_NORM, 0, 0);
    endtask

    // receiver stalls long, sender keeps offering until input backs up
    task automatic test_backpressure();
        write_register(REG_QUBITS, 6);
        sender_idle = 1'b0;
        rx_holdoff = 3000;
        repeat (2) @(posedge clk);
        send_command(CMD_H, 0, 0);
        send_command(CMD_H, 3, 0);
        send_command(CMD_CX, 0, 5);
        send_command(CMD_SAMPLE, 0, 0);
        send_command(CMD_NORM, 0, 0);
        send_command(CMD_MEASURE, 0, 0);
        send_command(CMD_X, 5, 0);
        wait_all_results();
    endtask

    task automatic test_random_sequence(int qcfg, int count);
        int n;
        int pick;
        int qa;
        int qb;
        cmd_t cmd;
        write_register(REG_QUBITS, qcfg);
        write_register(REG_SEED, ($urandom_range(0, 7) == 0) ? 64'd0
                                                          : {$urandom, $urandom});
        case ($urandom_range(0, 2))
            0: write_register(REG_TOL, 1);
            1: write_register(REG_TOL, 32'hFFFF_FFFF);
            default: write_register(REG_TOL, $urandom_range(1, 200000));
        endcase
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
        n = (qcfg == 0) ? 1 : ((qcfg > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : qcfg);
        for (int k = 0; k < count; k++)
        begin
            // sender pause mid-phase until every result is back
            if (k == count / 2) wait_all_results();
            pick = $urandom_range(0, 99);
            if (pick < 25)      cmd = CMD_H;
            else if (pick < 40) cmd = CMD_X;
            else if (pick < 58) cmd = CMD_CX;
            else if (pick < 70) cmd = CMD_SAMPLE;
            else if (pick < 80) cmd = CMD_MEASURE;
            else if (pick < 92) cmd = CMD_NORM;
            else if (pick < 96) cmd = CMD_GHZ;
            else                cmd = CMD_RESET;
            if ($urandom_range(0, 9) == 0)
            begin
                qa = $urandom_range(0, 15);
                qb = $urandom_range(0, 15);
            end
            else
            begin
                qa = $urandom_range(0, n - 1);
                qb = $urandom_range(0, n - 1);
                if (qb == qa && n > 1) qb = (qa + 1) % n;
            end
            send_command(cmd, qa, qb);
        end
    endtask

    // ---------------- main sequence ----------------
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_QUBITS;
        cfg_data = '0;
        fail_count = 0;
        sent_count = 0;
        checked_count = 0;
        draw_count = 0;
        rx_holdoff = 0;
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        qubit_reg = QUBITS_RST;
        tol_reg = TOL_RST;
        gen_word = DEFAULT_SEED;
        collapse_flag = 1'b0;
        load_basis(0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_one_qubit();
        test_multi_qubit_gates();
        test_backpressure();
        test_random_sequence(0, 50);    // zero acts as one qubit
        test_random_sequence(2, 70);
        test_random_sequence(3, 70);
        test_random_sequence(4, 70);
        test_random_sequence(5, 70);
        test_random_sequence(6, 60);
        test_random_sequence(7, 60);
        test_random_sequence(8, 50);
        test_random_sequence(15, 30);   // above max clamps to ten
        test_random_sequence(10, 30);

        wait_all_results();
        repeat (2100) @(posedge clk);
        $display("Ran %0d commands over qubit counts 1..10, %0d results checked, %0d draws",
                 sent_count, checked_count, draw_count);
        $display("Covered gates, GHZ, measure, sample, norm checks, range errors, stalls");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
